[rtl/cbs_pkg.sv]
package cbs_pkg;

   // Fixed field widths
   localparam int MV_W      = 16;
   localparam int TARGET_W  = 13;
   localparam int DUTY_W    = 6;
   localparam int MASK_W    = 8;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int CELL_FIELDS = 8;

   // Operation codes
   localparam logic OP_EVAL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FAULT    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SPREAD   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BALANCE_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_MV      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DUTY_TICKS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPREAD_MAX_MV  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_HIGH_MV  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ERROR_LOW_MV   = 3'd5;

   // Register reset values
   localparam logic [TARGET_W-1:0] RST_TARGET_MV     = 13'd4200;
   localparam logic [DUTY_W-1:0]   RST_DUTY_TICKS    = 6'd0;
   localparam logic [MV_W-1:0]     RST_SPREAD_MAX_MV = 16'd500;
   localparam logic [MV_W-1:0]     RST_ERROR_HIGH_MV = 16'd4300;
   localparam logic [MV_W-1:0]     RST_ERROR_LOW_MV  = 16'd2500;

   typedef struct packed {
      logic                balance_enable;
      logic [TARGET_W-1:0] target_mv;
      logic [DUTY_W-1:0]   duty_ticks;
      logic [MV_W-1:0]     spread_max_mv;
      logic [MV_W-1:0]     error_high_mv;
      logic [MV_W-1:0]     error_low_mv;
   } cfg_type;

   // What the lanes and the reduction found for one transaction
   typedef struct packed {
      logic              op;
      logic              fault;
      logic [MASK_W-1:0] above;
      logic [MV_W-1:0]   low_mv;
      logic [MV_W-1:0]   high_mv;
   } scan_type;

   typedef struct packed {
      logic [MASK_W-1:0]   drive_mask;
      logic [MASK_W-1:0]   selected_mask;
      logic [STATUS_W-1:0] status;
      logic                phase_on;
   } result_type;

endpackage

[rtl/cbs_if.sv]
interface cbs_req_if;
   logic                     valid;
   logic                     ready;
   logic                     op;
   logic [cbs_pkg::MV_W-1:0] cell_mv_0;
   logic [cbs_pkg::MV_W-1:0] cell_mv_1;
   logic [cbs_pkg::MV_W-1:0] cell_mv_2;
   logic [cbs_pkg::MV_W-1:0] cell_mv_3;
   logic [cbs_pkg::MV_W-1:0] cell_mv_4;
   logic [cbs_pkg::MV_W-1:0] cell_mv_5;
   logic [cbs_pkg::MV_W-1:0] cell_mv_6;
   logic [cbs_pkg::MV_W-1:0] cell_mv_7;

   modport source (
      output valid, op, cell_mv_0, cell_mv_1, cell_mv_2, cell_mv_3,
             cell_mv_4, cell_mv_5, cell_mv_6, cell_mv_7,
      input  ready
   );
   modport sink (
      input  valid, op, cell_mv_0, cell_mv_1, cell_mv_2, cell_mv_3,
             cell_mv_4, cell_mv_5, cell_mv_6, cell_mv_7,
      output ready
   );
endinterface

interface cbs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [cbs_pkg::MASK_W-1:0]   drive_mask;
   logic [cbs_pkg::MASK_W-1:0]   selected_mask;
   logic [cbs_pkg::STATUS_W-1:0] status;
   logic                         phase_on;

   modport source (
      output valid, drive_mask, selected_mask, status, phase_on,
      input  ready
   );
   modport sink (
      input  valid, drive_mask, selected_mask, status, phase_on,
      output ready
   );
endinterface

interface cbs_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cbs_pkg::CSR_IDX_W-1:0] index;
   logic [cbs_pkg::CSR_DAT_W-1:0] data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

[rtl/cbs_lane.sv]
// Per-cell checks: limit fault and above-target flag.
module cbs_lane (
   input  logic [cbs_pkg::MV_W-1:0] cell_mv,
   input  cbs_pkg::cfg_type         cfg,
   output logic                     fault,
   output logic                     above
);

   assign fault = (cell_mv >= cfg.error_high_mv) || (cell_mv <= cfg.error_low_mv);
   assign above = cell_mv > {{(cbs_pkg::MV_W-cbs_pkg::TARGET_W){1'b0}}, cfg.target_mv};

endmodule

[rtl/cbs_minmax.sv]
// Lowest and highest reading across the active lanes.
module cbs_minmax #(
   parameter int LANES = 8
) (
   input  logic [cbs_pkg::MV_W-1:0] cell_mv [LANES],
   output logic [cbs_pkg::MV_W-1:0] low_mv,
   output logic [cbs_pkg::MV_W-1:0] high_mv
);

   always_comb begin
      low_mv  = cell_mv[0];
      high_mv = cell_mv[0];
      for (int i = 1; i < LANES; i++) begin
         if (cell_mv[i] < low_mv) begin
            low_mv = cell_mv[i];
         end
         if (cell_mv[i] > high_mv) begin
            high_mv = cell_mv[i];
         end
      end
   end

endmodule

[rtl/cbs_merge.sv]
// Merge stage: spread test, status, selection and period counter state,
// registered result.
module cbs_merge #(
   parameter int PWM_PERIOD = 100
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  cbs_pkg::scan_type    scan,
   input  cbs_pkg::cfg_type     cfg,
   output cbs_pkg::result_type  result
);

   localparam logic [cbs_pkg::COUNT_W-1:0] PERIOD = cbs_pkg::COUNT_W'(PWM_PERIOD);

   logic [cbs_pkg::MASK_W-1:0]  selection_ff, selection_in;
   logic [cbs_pkg::COUNT_W-1:0] count_ff, count_in;
   cbs_pkg::result_type         result_ff, result_in;

   logic [cbs_pkg::MV_W-1:0]    spread_mv;
   logic [cbs_pkg::COUNT_W-1:0] count_inc;
   logic [cbs_pkg::MASK_W-1:0]  sel_base;
   logic                        phase;

   assign spread_mv = scan.high_mv - scan.low_mv;
   assign count_inc = count_ff + 1'b1;
   assign sel_base  = cfg.balance_enable ? selection_ff : '0;
   assign phase     = count_inc < {1'b0, cfg.duty_ticks};

   always_comb begin
      selection_in = selection_ff;
      count_in     = count_ff;
      result_in    = result_ff;
      if (advance) begin
         result_in.drive_mask = '0;
         result_in.phase_on   = 1'b0;
         result_in.status     = cbs_pkg::STATUS_OK;
         if (scan.op == cbs_pkg::OP_EVAL) begin
            if (!cfg.balance_enable) begin
               selection_in     = '0;
               result_in.status = cbs_pkg::STATUS_DISABLED;
            end else if (scan.fault) begin
               result_in.status = cbs_pkg::STATUS_FAULT;
            end else if (spread_mv > cfg.spread_max_mv) begin
               result_in.status = cbs_pkg::STATUS_SPREAD;
            end else begin
               selection_in = scan.above;
            end
         end else begin
            selection_in         = sel_base;
            result_in.phase_on   = phase;
            result_in.drive_mask = phase ? sel_base : '0;
            count_in             = (count_inc >= PERIOD) ? '0 : count_inc;
         end
         result_in.selected_mask = selection_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selection_ff <= '0;
         count_ff     <= '0;
      end else begin
         selection_ff <= selection_in;
         count_ff     <= count_in;
      end
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

[rtl/cell_balance_selector_pwm.sv]
// Channel  | Dir | Handshake    | Carries
// ---------+-----+--------------+---------------------------------------------
// req_chan | in  | valid/ready  | op, cell_mv_0..cell_mv_7
// rsp_chan | out | valid/ready  | drive_mask, selected_mask, status, phase_on
// csr_chan | in  | valid/ready  | index (register number), data
//
// Two register stages: the lanes and the min/max reduction fill the scan
// register, the merge stage updates selection and period counter and loads
// the result register. One transaction per cycle unless rsp_chan stalls.
// Reset (synchronous, active high) empties both stages, clears selection and
// counter, and loads register defaults. The scan register frees as soon as
// the result moves on; with a result stalled one more request is taken into
// the scan register, then req_chan.ready drops until rsp_chan.ready returns.
// csr_chan is always ready; writes are registered and apply from the next cycle.
module cell_balance_selector_pwm #(
   parameter int NUM_CELLS  = 8,
   parameter int PWM_PERIOD = 100
) (
   input  logic      clock,
   input  logic      reset,
   cbs_req_if.sink   req_chan,
   cbs_rsp_if.source rsp_chan,
   cbs_csr_if.sink   csr_chan
);

   // Only the cells the input carries can take part.
   localparam int LANES = (NUM_CELLS > cbs_pkg::CELL_FIELDS) ?
                          cbs_pkg::CELL_FIELDS : NUM_CELLS;

   // ---------------- configuration registers ----------------
   cbs_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            cbs_pkg::REG_BALANCE_ENABLE: cfg_in.balance_enable = csr_chan.data[0];
            cbs_pkg::REG_TARGET_MV:
               cfg_in.target_mv = csr_chan.data[cbs_pkg::TARGET_W-1:0];
            cbs_pkg::REG_DUTY_TICKS:
               cfg_in.duty_ticks = csr_chan.data[cbs_pkg::DUTY_W-1:0];
            cbs_pkg::REG_SPREAD_MAX_MV: cfg_in.spread_max_mv = csr_chan.data;
            cbs_pkg::REG_ERROR_HIGH_MV: cfg_in.error_high_mv = csr_chan.data;
            cbs_pkg::REG_ERROR_LOW_MV:  cfg_in.error_low_mv  = csr_chan.data;
            default: ;  // unmapped index: write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.balance_enable <= 1'b0;
         cfg_ff.target_mv      <= cbs_pkg::RST_TARGET_MV;
         cfg_ff.duty_ticks     <= cbs_pkg::RST_DUTY_TICKS;
         cfg_ff.spread_max_mv  <= cbs_pkg::RST_SPREAD_MAX_MV;
         cfg_ff.error_high_mv  <= cbs_pkg::RST_ERROR_HIGH_MV;
         cfg_ff.error_low_mv   <= cbs_pkg::RST_ERROR_LOW_MV;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic scan_valid_ff, scan_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free, scan_free, req_fire, advance;

   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign advance   = scan_valid_ff && rsp_free;
   assign scan_free = !scan_valid_ff || rsp_free;
   assign req_fire  = req_chan.valid && scan_free;

   assign req_chan.ready = scan_free;

   always_comb begin
      scan_valid_in = scan_free ? req_chan.valid : scan_valid_ff;
      rsp_valid_in  = rsp_free ? scan_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_valid_ff <= scan_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------- lanes ----------------
   logic [cbs_pkg::MV_W-1:0] cell_all [cbs_pkg::CELL_FIELDS];
   logic [cbs_pkg::MV_W-1:0] cell_mv  [LANES];
   logic [LANES-1:0]         lane_fault;
   logic [LANES-1:0]         lane_above;
   logic [cbs_pkg::MV_W-1:0] low_mv, high_mv;

   assign cell_all[0] = req_chan.cell_mv_0;
   assign cell_all[1] = req_chan.cell_mv_1;
   assign cell_all[2] = req_chan.cell_mv_2;
   assign cell_all[3] = req_chan.cell_mv_3;
   assign cell_all[4] = req_chan.cell_mv_4;
   assign cell_all[5] = req_chan.cell_mv_5;
   assign cell_all[6] = req_chan.cell_mv_6;
   assign cell_all[7] = req_chan.cell_mv_7;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign cell_mv[i] = cell_all[i];
      cbs_lane u_lane (
         .cell_mv (cell_mv[i]),
         .cfg     (cfg_ff),
         .fault   (lane_fault[i]),
         .above   (lane_above[i])
      );
   end

   cbs_minmax #(
      .LANES (LANES)
   ) u_minmax (
      .cell_mv (cell_mv),
      .low_mv  (low_mv),
      .high_mv (high_mv)
   );

   // ---------------- scan register ----------------
   cbs_pkg::scan_type scan_ff, scan_in;

   always_comb begin
      scan_in = scan_ff;
      if (req_fire) begin
         scan_in.op      = req_chan.op;
         scan_in.fault   = |lane_fault;
         scan_in.above   = cbs_pkg::MASK_W'(lane_above);  // unused cells stay clear
         scan_in.low_mv  = low_mv;
         scan_in.high_mv = high_mv;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   // ---------------- merge stage ----------------
   cbs_pkg::result_type result;

   cbs_merge #(
      .PWM_PERIOD (PWM_PERIOD)
   ) u_merge (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .scan    (scan_ff),
      .cfg     (cfg_ff),
      .result  (result)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.drive_mask    = result.drive_mask;
   assign rsp_chan.selected_mask = result.selected_mask;
   assign rsp_chan.status        = result.status;
   assign rsp_chan.phase_on      = result.phase_on;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
   import cbs_pkg::*;

   // Block configuration used for the instance and the predictor
   localparam int NUM_CELLS  = 8;
   localparam int PWM_TICKS  = 100;
   // Cycles without any transaction before the run is declared hung
   localparam int HANG_LIMIT = 1000;
   // Length of the deliberate result back-pressure stretch
   localparam int HOLDOFF_CYCLES = 80;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 100;

   // One request: the op code and all eight cell readings
   typedef struct packed {
      logic                                op;
      logic [CELL_FIELDS-1:0][MV_W-1:0]   mv;
   } cell_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   cbs_req_if req_chan ();
   cbs_rsp_if rsp_chan ();
   cbs_csr_if csr_chan ();

   cell_balance_selector_pwm #(
      .NUM_CELLS  (NUM_CELLS),
      .PWM_PERIOD (PWM_TICKS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Requests waiting for the driver, and results the block still owes us
   cell_item_type queued_cells[$];
   result_type    balance_due[$];

   // Predictor's copy of the registers and of the block state
   cfg_type            cfg_model;
   logic [MASK_W-1:0]  sel_model;
   logic [COUNT_W-1:0] pwm_count_model;

   int  mismatches   = 0;
   int  idle_cycles  = 0;
   // Random idling on both channels; cleared for the no-gap stretch
   bit  gaps_on      = 1'b1;
   // Bumping holdoff_gen asks the result side for one long stall
   int  holdoff_gen  = 0;
   int  holdoff_seen = 0;
   int  holdoff_left = 0;

   // ------------------------------------------------------------------
   // Predictor: next result and state update for one accepted request
   // ------------------------------------------------------------------
   function automatic result_type predict_balance(cell_item_type it);
      result_type        r;
      logic [MV_W-1:0]   lowest;
      logic [MASK_W-1:0] above;
      logic              faulty;
      logic              too_wide;
      r = '0;
      if (it.op == OP_EVAL) begin
         // evaluation never drives the switches, phase stays off
         if (!cfg_model.balance_enable) begin
            sel_model = '0;
            r.status  = STATUS_DISABLED;
         end else begin
            faulty   = 1'b0;
            too_wide = 1'b0;
            lowest   = '1;
            above    = '0;
            for (int k = 0; k < NUM_CELLS; k++) begin
               if (it.mv[k] >= cfg_model.error_high_mv || it.mv[k] <= cfg_model.error_low_mv)
                  faulty = 1'b1;
               if (it.mv[k] < lowest)
                  lowest = it.mv[k];
            end
            for (int k = 0; k < NUM_CELLS; k++) begin
               if (it.mv[k] - lowest > cfg_model.spread_max_mv)
                  too_wide = 1'b1;
               if (it.mv[k] > {3'b000, cfg_model.target_mv})
                  above[k] = 1'b1;
            end
            // voltage fault wins over spread; either keeps the old selection
            if (faulty) begin
               r.status = STATUS_FAULT;
            end else if (too_wide) begin
               r.status = STATUS_SPREAD;
            end else begin
               sel_model = above;
               r.status  = STATUS_OK;
            end
         end
      end else begin
         // tick: counter runs even when disabled, on-phase is new count < duty
         if (!cfg_model.balance_enable)
            sel_model = '0;
         pwm_count_model = pwm_count_model + 1'b1;
         if (pwm_count_model < cfg_model.duty_ticks) begin
            r.phase_on   = 1'b1;
            r.drive_mask = sel_model;
         end
         if (pwm_count_model >= PWM_TICKS)
            pwm_count_model = '0;
      end
      r.selected_mask = sel_model;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: offers queued items, predicts on acceptance
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      cell_item_type offered;
      cell_item_type nxt;
      logic          offer;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            balance_due.push_back(predict_balance(offered));
         // free to move on when nothing is offered or the offer was taken
         if (!req_chan.valid || req_chan.ready) begin
            offer = queued_cells.size() != 0 && !(gaps_on && $urandom_range(99, 0) < 22);
            if (offer) begin
               nxt     = queued_cells.pop_front();
               offered = nxt;
               req_chan.op        <= nxt.op;
               req_chan.cell_mv_0 <= nxt.mv[0];
               req_chan.cell_mv_1 <= nxt.mv[1];
               req_chan.cell_mv_2 <= nxt.mv[2];
               req_chan.cell_mv_3 <= nxt.mv[3];
               req_chan.cell_mv_4 <= nxt.mv[4];
               req_chan.cell_mv_5 <= nxt.mv[5];
               req_chan.cell_mv_6 <= nxt.mv[6];
               req_chan.cell_mv_7 <= nxt.mv[7];
            end
            req_chan.valid <= offer;
         end
      end
   end

   task automatic flag_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // ------------------------------------------------------------------
   // Result monitor: compares each transaction with the oldest prediction
   // and drives ready, including the one long holdoff
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (balance_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual drive %0d sel %0d",
                        $time, rsp_chan.drive_mask, rsp_chan.selected_mask);
            end else begin
               want = balance_due.pop_front();
               flag_field("drive_mask", want.drive_mask, rsp_chan.drive_mask);
               flag_field("selected_mask", want.selected_mask, rsp_chan.selected_mask);
               flag_field("status", want.status, rsp_chan.status);
               flag_field("phase_on", want.phase_on, rsp_chan.phase_on);
            end
         end
         if (holdoff_gen != holdoff_seen) begin
            holdoff_seen = holdoff_gen;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= !(gaps_on && $urandom_range(99, 0) < 22);
         end
      end
   end

   // Hang detection: any transaction on any channel restarts the count
   always @(posedge clock) begin : hang_watch
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Register write; the predictor copy follows once the write is taken
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         REG_BALANCE_ENABLE: cfg_model.balance_enable = value[0];
         REG_TARGET_MV:      cfg_model.target_mv      = value[TARGET_W-1:0];
         REG_DUTY_TICKS:     cfg_model.duty_ticks     = value[DUTY_W-1:0];
         REG_SPREAD_MAX_MV:  cfg_model.spread_max_mv  = value;
         REG_ERROR_HIGH_MV:  cfg_model.error_high_mv  = value;
         REG_ERROR_LOW_MV:   cfg_model.error_low_mv   = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Writes all six registers; unused high data bits are filled with noise
   task automatic program_regs(input logic en, input logic [TARGET_W-1:0] tgt,
                               input logic [DUTY_W-1:0] duty, input logic [MV_W-1:0] spread,
                               input logic [MV_W-1:0] hi, input logic [MV_W-1:0] lo);
      logic [15:0] junk;
      junk = 16'($urandom);
      write_reg(REG_BALANCE_ENABLE, {junk[15:1], en});
      write_reg(REG_TARGET_MV, {junk[15:13], tgt});
      write_reg(REG_DUTY_TICKS, {junk[15:6], duty});
      write_reg(REG_SPREAD_MAX_MV, spread);
      write_reg(REG_ERROR_HIGH_MV, hi);
      write_reg(REG_ERROR_LOW_MV, lo);
   endtask

   // Block idle: nothing queued, nothing offered, nothing owed
   task automatic drain();
      do @(negedge clock);
      while (queued_cells.size() != 0 || req_chan.valid || balance_due.size() != 0);
   endtask

   function automatic cell_item_type uniform_eval(input logic [MV_W-1:0] v);
      cell_item_type it;
      it.op = OP_EVAL;
      for (int k = 0; k < CELL_FIELDS; k++)
         it.mv[k] = v;
      return it;
   endfunction

   // Random request. Ticks carry random (ignored) cells. Evaluations are
   // mostly well-formed sets inside the error window and within the spread
   // limit, with some faults, spread violations and raw noise mixed in.
   function automatic cell_item_type random_item();
      cell_item_type it;
      int pick;
      int lo_ok;
      int hi_ok;
      int base;
      int room;
      int k;
      it.op = OP_TICK;
      for (int j = 0; j < CELL_FIELDS; j++)
         it.mv[j] = MV_W'($urandom);
      if ($urandom_range(99, 0) < 50)
         return it;
      it.op = OP_EVAL;
      pick  = $urandom_range(99, 0);
      if (pick < 10)
         return it;
      lo_ok = int'(cfg_model.error_low_mv) + 1;
      hi_ok = int'(cfg_model.error_high_mv) - 1;
      if (hi_ok < lo_ok)
         return it;   // window closed: every reading faults anyway
      base = $urandom_range(hi_ok, lo_ok);
      room = hi_ok - base;
      if (int'(cfg_model.spread_max_mv) < room)
         room = int'(cfg_model.spread_max_mv);
      for (int j = 0; j < CELL_FIELDS; j++)
         it.mv[j] = MV_W'(base + $urandom_range(room, 0));
      k = $urandom_range(CELL_FIELDS - 1, 0);
      if (pick < 25) begin
         case ($urandom_range(3, 0))
            0: it.mv[k] = '1;                      // invalid reading
            1: it.mv[k] = '0;
            2: it.mv[k] = cfg_model.error_high_mv;
            default: it.mv[k] = cfg_model.error_low_mv;
         endcase
      end else if (pick < 40 && base + int'(cfg_model.spread_max_mv) < 65535) begin
         // pin the minimum, push one cell just past the spread limit
         it.mv[(k + 1) % CELL_FIELDS] = MV_W'(base);
         it.mv[k] = MV_W'(base + int'(cfg_model.spread_max_mv) + 1 +
                          int'($urandom_range(3, 0)));
      end
      return it;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      cell_item_type it;
      req_chan.valid     = 1'b0;
      req_chan.op        = OP_EVAL;
      req_chan.cell_mv_0 = '0;
      req_chan.cell_mv_1 = '0;
      req_chan.cell_mv_2 = '0;
      req_chan.cell_mv_3 = '0;
      req_chan.cell_mv_4 = '0;
      req_chan.cell_mv_5 = '0;
      req_chan.cell_mv_6 = '0;
      req_chan.cell_mv_7 = '0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.index     = REG_BALANCE_ENABLE;
      csr_chan.data      = '0;

      // register defaults and cleared state, as after reset
      cfg_model.balance_enable = 1'b0;
      cfg_model.target_mv      = RST_TARGET_MV;
      cfg_model.duty_ticks     = RST_DUTY_TICKS;
      cfg_model.spread_max_mv  = RST_SPREAD_MAX_MV;
      cfg_model.error_high_mv  = RST_ERROR_HIGH_MV;
      cfg_model.error_low_mv   = RST_ERROR_LOW_MV;
      sel_model       = '0;
      pwm_count_model = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset defaults leave balancing disabled: evaluation reports it,
      // a tick drives nothing
      queued_cells.push_back(uniform_eval(16'd4100));
      it    = uniform_eval(16'd0);
      it.op = OP_TICK;
      queued_cells.push_back(it);
      drain();

      // Directed pass: boundaries of the fault window, spread and target
      program_regs(1'b1, 13'd4000, 6'd3, 16'd500, 16'd4300, 16'd2500);
      queued_cells.push_back(uniform_eval(16'd3900));     // nothing above target
      queued_cells.push_back(uniform_eval(16'd4001));     // all just above target
      it = uniform_eval(16'd4000);                        // exactly at target: not chosen
      for (int k = 1; k < CELL_FIELDS; k += 2)
         it.mv[k] = 16'd4001;
      queued_cells.push_back(it);
      for (int n = 0; n < 4; n++) begin                   // on, off, off, off
         it    = uniform_eval(16'hFFFF);
         it.op = OP_TICK;
         queued_cells.push_back(it);
      end
      it = uniform_eval(16'd2501);                        // spread exactly at limit
      it.mv[5] = 16'd3001;
      queued_cells.push_back(it);
      it.mv[5] = 16'd3002;                                // one past the limit
      queued_cells.push_back(it);
      it = uniform_eval(16'd4100);                        // at the low fault limit
      it.mv[2] = 16'd2500;
      queued_cells.push_back(it);
      it.mv[2] = 16'd4300;                                // at the high fault limit
      queued_cells.push_back(it);
      it.mv[2] = 16'hFFFF;                                // invalid reading
      queued_cells.push_back(it);
      queued_cells.push_back(uniform_eval(16'd0));
      queued_cells.push_back(uniform_eval(16'hFFFF));
      it = uniform_eval(16'd4299);                        // fault and spread: fault wins
      it.mv[0] = 16'd2500;
      queued_cells.push_back(it);
      queued_cells.push_back(uniform_eval(16'd4299));     // top of the window, all chosen
      for (int n = 0; n < 3; n++) begin
         it    = uniform_eval(16'h5A5A);
         it.op = OP_TICK;
         queued_cells.push_back(it);
      end
      drain();

      // Random phases, each with its own register set; the drain between
      // them is the sender pause until every result is back
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: program_regs(1'b1, '0, '0, '0, '1, '0);         // all minima, wide window
            1: program_regs(1'b1, '1, '1, '1, '1, '0);         // maxima, error low limit zero
            2: program_regs(1'b0, 13'd3700, 6'd49, 16'd500, 16'd4300, 16'd2500);
            3: program_regs(1'b1, 13'd3600, 6'd20, 16'd300, '0, '1); // every reading faults
            default: program_regs(1'b1, TARGET_W'($urandom_range(4200, 3200)),
                                  DUTY_W'($urandom_range(49, 0)),
                                  MV_W'($urandom_range(600, 0)),
                                  MV_W'($urandom_range(4400, 4200)),
                                  MV_W'($urandom_range(3000, 2400)));
         endcase
         // one phase runs flat out, no idling on either side
         gaps_on = (p != 4);
         for (int n = 0; n < PHASE_ITEMS; n++)
            queued_cells.push_back(random_item());
         // one phase stalls results for a long stretch while requests keep coming
         if (p == 6)
            holdoff_gen++;
         drain();
      end
      gaps_on = 1'b1;

      // results are all in; let the two-stage pipe show any stray output
      repeat (6) @(negedge clock);
      if (mismatches == 0 && balance_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
